FILE: src/trle_pkg.sv
`timescale 1ns / 1ps

package trle_pkg;

  // Default widths of the run counter and of the running totals
  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_TOTAL_BITS = 32;

  // Result bytes delivered per input request; the rest are only counted
  localparam int RES_CNT_BITS = 4;
  localparam logic [RES_CNT_BITS-1:0] MAX_RESULTS = 4'd12;

  // ASCII code of the digit zero
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EOF,
    ST_LOAD,
    ST_BYTE,
    ST_SKIP,
    ST_DIGIT
  } trle_state_t;

  // Commands to the decimal converter
  typedef struct packed {
    logic load;
    logic shift;
  } trle_cvt_ctrl_t;

  // Status of the decimal converter
  typedef struct packed {
    logic       done;
    logic       last_digit;
    logic [3:0] digit;
  } trle_cvt_stat_t;

  // Decimal digits needed for the largest count of the given width
  function automatic int dec_digits(input int bits);
    logic [64:0] v;
    int          n;
    v = (65'd1 << bits) - 65'd1;
    n = 1;
    v = v / 10;
    while (v != 65'd0) begin
      n = n + 1;
      v = v / 10;
    end
    return n;
  endfunction

endpackage

FILE: src/trle_bcd.sv
`timescale 1ns / 1ps

module trle_bcd import trle_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  trle_cvt_ctrl_t        ctrl,
  input  logic [COUNT_BITS-1:0] value,
  output trle_cvt_stat_t        stat
);

  localparam int NDIG = dec_digits(COUNT_BITS);
  localparam int BCD_BITS = NDIG * 4;
  localparam int BIT_CNT_BITS = $clog2(COUNT_BITS + 1);
  localparam int DIG_CNT_BITS = $clog2(NDIG + 1);

  logic [COUNT_BITS-1:0]   bin_sr;
  logic [BCD_BITS-1:0]     bcd;
  logic [BCD_BITS-1:0]     bcd_adj;
  logic [BIT_CNT_BITS-1:0] bit_cnt;
  logic [DIG_CNT_BITS-1:0] dig_left;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Count bits in and digits out
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt  <= '0;
      dig_left <= '0;
    end else if (ctrl.load) begin
      bit_cnt  <= BIT_CNT_BITS'(COUNT_BITS);
      dig_left <= DIG_CNT_BITS'(NDIG);
    end else if (bit_cnt != '0) begin
      bit_cnt <= bit_cnt - 1'b1;
    end else if (ctrl.shift) begin
      dig_left <= dig_left - 1'b1;
    end
  end

  // Shift one binary bit in per cycle, then one digit out per shift command
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin_sr <= value;
      bcd    <= '0;
    end else if (bit_cnt != '0) begin
      bin_sr <= {bin_sr[COUNT_BITS-2:0], 1'b0};
      bcd    <= {bcd_adj[BCD_BITS-2:0], bin_sr[COUNT_BITS-1]};
    end else if (ctrl.shift) begin
      bcd <= {bcd[BCD_BITS-5:0], 4'd0};
    end
  end

  assign stat.done       = (bit_cnt == '0);
  assign stat.last_digit = (dig_left == DIG_CNT_BITS'(1));
  assign stat.digit      = bcd[BCD_BITS-1 -: 4];

endmodule

FILE: src/text_run_length_encoder.sv
`timescale 1ns / 1ps
// Run-length encoder for byte streams with decimal ASCII counts.
// Input channel: in_byte plus end_of_file, moved by in_valid / in_stall.
// Output channel: one byte per request (run byte or count digit) with
// last_of_run and the running read and written totals, moved by out_valid /
// out_stall.
// A request that only extends a run leaves the encoder idle. A request that
// closes a run emits the run byte followed by its count, most significant
// digit first; the run byte is emitted from the byte state after the load
// state, with the end-of-file state ahead of the load state when only the
// end of file closes the run. The bit-serial binary-to-decimal converter
// takes one bit per cycle and then skips or emits one digit per cycle, an
// emitted digit waiting while the receiver stalls. A request ending a file
// right after a run change closes two runs back to back.
// Up to twelve results are delivered per request; further ones are counted.
// Synchronous reset clears the open run, both internal running sums and the output valid flag.
// A stalled receiver holds the output register and pauses the encoder; an
// input request is taken again once the last result sits in that register.
module text_run_length_encoder import trle_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int TOTAL_BITS = DEF_TOTAL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic [31:0] read_total,
  output logic [31:0] written_total
);

  trle_state_t             state, state_next;
  logic                    run_open, run_open_next;
  logic [7:0]              run_byte, run_byte_next;
  logic [COUNT_BITS-1:0]   run_length, run_length_next;
  logic [TOTAL_BITS-1:0]   read_sum, read_sum_next;
  logic [TOTAL_BITS-1:0]   written_sum, written_sum_next;
  logic [TOTAL_BITS-1:0]   written_inc;
  logic [7:0]              fl_byte, fl_byte_next;
  logic [COUNT_BITS-1:0]   fl_len, fl_len_next;
  logic                    eof_pend, eof_pend_next;
  logic [RES_CNT_BITS-1:0] res_cnt, res_cnt_next;
  logic                    out_valid_next;
  logic [7:0]              out_byte_next;
  logic                    last_of_run_next;
  logic [31:0]             read_total_next;
  logic [31:0]             written_total_next;

  logic                    emit;
  logic [7:0]              emit_byte;
  logic                    emit_last;
  logic                    emit_ok;
  logic                    drop;
  logic                    flush_old;
  trle_cvt_ctrl_t          cvt_ctrl;
  trle_cvt_stat_t          cvt_stat;

  trle_bcd #(
    .COUNT_BITS(COUNT_BITS)
  ) u_bcd (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cvt_ctrl),
    .value(fl_len),
    .stat (cvt_stat)
  );

  assign drop        = (res_cnt == MAX_RESULTS);
  assign emit_ok     = drop || !out_valid || !out_stall;
  assign written_inc = written_sum + TOTAL_BITS'(1);

  // Next state, run bookkeeping and result generation
  always_comb begin
    state_next         = state;
    run_open_next      = run_open;
    run_byte_next      = run_byte;
    run_length_next    = run_length;
    read_sum_next      = read_sum;
    written_sum_next   = written_sum;
    fl_byte_next       = fl_byte;
    fl_len_next        = fl_len;
    eof_pend_next      = eof_pend;
    res_cnt_next       = res_cnt;
    out_valid_next     = out_valid;
    out_byte_next      = out_byte;
    last_of_run_next   = last_of_run;
    read_total_next    = read_total;
    written_total_next = written_total;
    cvt_ctrl           = '0;
    emit               = 1'b0;
    emit_byte          = fl_byte;
    emit_last          = 1'b0;
    flush_old          = 1'b0;
    in_stall           = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_cnt_next  = '0;
          eof_pend_next = end_of_file;
          if (!run_open) begin
            run_open_next   = 1'b1;
            run_byte_next   = in_byte;
            run_length_next = COUNT_BITS'(1);
          end else if (in_byte != run_byte || &run_length) begin
            flush_old       = 1'b1;
            fl_byte_next    = run_byte;
            fl_len_next     = run_length;
            run_byte_next   = in_byte;
            run_length_next = COUNT_BITS'(1);
          end else begin
            run_length_next = run_length + COUNT_BITS'(1);
          end
          if (flush_old) begin
            state_next = ST_LOAD;
          end else if (end_of_file) begin
            state_next = ST_EOF;
          end
        end
      end
      // Close the open run at end of file
      ST_EOF: begin
        fl_byte_next    = run_byte;
        fl_len_next     = run_length;
        run_open_next   = 1'b0;
        run_length_next = '0;
        eof_pend_next   = 1'b0;
        state_next      = ST_LOAD;
      end
      // Start the conversion and count the run into the read total
      ST_LOAD: begin
        cvt_ctrl.load = 1'b1;
        read_sum_next = read_sum + TOTAL_BITS'(fl_len);
        state_next    = ST_BYTE;
      end
      ST_BYTE: begin
        if (emit_ok) begin
          emit       = 1'b1;
          emit_byte  = fl_byte;
          emit_last  = (res_cnt == MAX_RESULTS - 1'b1);
          state_next = ST_SKIP;
        end
      end
      // Drop leading zeros once the conversion is done
      ST_SKIP: begin
        if (cvt_stat.done) begin
          if (cvt_stat.digit == 4'd0 && !cvt_stat.last_digit) begin
            cvt_ctrl.shift = 1'b1;
          end else begin
            state_next = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        if (emit_ok) begin
          emit           = 1'b1;
          emit_byte      = DIGIT_BASE + 8'(cvt_stat.digit);
          emit_last      = (res_cnt == MAX_RESULTS - 1'b1) ||
                           (cvt_stat.last_digit && !eof_pend);
          cvt_ctrl.shift = 1'b1;
          if (cvt_stat.last_digit) begin
            state_next = eof_pend ? ST_EOF : ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Retire the output register once taken
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    // Count every result; deliver it unless past the per-request limit
    if (emit) begin
      written_sum_next = written_inc;
      if (!drop) begin
        out_valid_next     = 1'b1;
        out_byte_next      = emit_byte;
        last_of_run_next   = emit_last;
        read_total_next    = 32'(read_sum);
        written_total_next = 32'(written_inc);
        res_cnt_next       = res_cnt + 1'b1;
      end
    end
  end

  // Control and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      run_open    <= 1'b0;
      run_byte    <= '0;
      run_length  <= '0;
      read_sum    <= '0;
      written_sum <= '0;
      eof_pend    <= 1'b0;
      res_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      run_open    <= run_open_next;
      run_byte    <= run_byte_next;
      run_length  <= run_length_next;
      read_sum    <= read_sum_next;
      written_sum <= written_sum_next;
      eof_pend    <= eof_pend_next;
      res_cnt     <= res_cnt_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fl_byte       <= fl_byte_next;
    fl_len        <= fl_len_next;
    out_byte      <= out_byte_next;
    last_of_run   <= last_of_run_next;
    read_total    <= read_total_next;
    written_total <= written_total_next;
  end

endmodule
